@@ rtl/btr_pkg.sv @@
// ----------------------------------------------------------------------------
// btr_pkg
// Shared types, constants and helpers of the bitmap text row renderer.
// ----------------------------------------------------------------------------
package btr_pkg;

  localparam int unsigned GLYPH_COUNT = 96;
  localparam int unsigned MAX_ROWS    = 16;
  localparam int unsigned TABLE_DEPTH = 1536;
  localparam int unsigned ADDR_W      = 11;
  localparam int unsigned SUM_W       = 17;
  localparam int unsigned ACC_W       = 13;

  localparam logic [7:0] FIRST_GLYPH  = 8'd32;
  localparam logic [7:0] NEWLINE_CODE = 8'd10;

  typedef enum logic [1:0] {
    KIND_CHAR   = 2'd0,
    KIND_CURSOR = 2'd1,
    KIND_TABLE  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    REG_GLYPH_WIDTH  = 2'd0,
    REG_GLYPH_HEIGHT = 2'd1,
    REG_CLIP_LEFT    = 2'd2,
    REG_CLIP_RIGHT   = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_NEWLINE,
    ST_MUL,
    ST_CHECK,
    ST_FETCH,
    ST_ROW,
    ST_ADVANCE,
    ST_WRAP
  } state_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  char_code;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [10:0] table_index;
    logic [15:0] table_word;
  } in_t;

  typedef struct packed {
    logic [15:0] row_x;
    logic [15:0] row_y;
    logic [15:0] pixel_mask;
    logic        last_row;
  } out_t;

  typedef struct packed {
    logic [SUM_W-1:0] a;
    logic [SUM_W-1:0] b;
    logic [SUM_W-1:0] lim;
  } alu_req_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             gt;
  } alu_rsp_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [15:0]       wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } mem_req_t;

  // keeps the top w bits of a row word, msb is the leftmost pixel
  function automatic logic [15:0] width_mask(input logic [4:0] w);
    logic [15:0] m;
    if (w >= 5'd16) begin
      m = 16'hFFFF;
    end else begin
      m = ~(16'hFFFF >> w);
    end
    return m;
  endfunction

endpackage

@@ rtl/bitmap_text_row_renderer.sv @@
// ----------------------------------------------------------------------------
// bitmap_text_row_renderer
// Draws character codes with a loaded bitmap font, one output beat per row.
//
//   channel  direction  payload               handshake
//   in       input      btr_pkg::in_t         in_valid / in_ready
//   out      output     btr_pkg::out_t        out_valid / out_ready
//   cfg      input      cfg_index, cfg_data   cfg_valid / cfg_ready
//
// Set cursor, table write and unknown kinds pass only the decode step, a
// newline also the newline step. A character runs five shift-add steps of
// the shared adder to form the table base and a check; a drawn one then
// streams rows one per cycle from the font memory read port, unless the
// output stalls, and a wrap to a new line adds the newline step.
// Reset clears the cursor and sequencer, presets the registers; the font table
// holds no reset value. An output stall holds the row loop where it is.
// ----------------------------------------------------------------------------
module bitmap_text_row_renderer (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  btr_pkg::in_t      in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output btr_pkg::out_t     out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  btr_pkg::cfg_reg_t cfg_index,
  input  logic [15:0]       cfg_data
);

  btr_pkg::state_t   state;
  btr_pkg::state_t   state_next;
  btr_pkg::in_t      item;
  btr_pkg::alu_req_t alu_req;
  btr_pkg::alu_rsp_t alu_rsp;
  btr_pkg::mem_req_t mem_req;

  logic [4:0]  glyph_width;
  logic [4:0]  glyph_height;
  logic [15:0] clip_left;
  logic [15:0] clip_right;
  logic [15:0] cursor_x;
  logic [15:0] cursor_y;

  logic [btr_pkg::ACC_W-1:0]  acc;
  logic [2:0]                 mul_step;
  logic [btr_pkg::ADDR_W-1:0] addr;
  logic [4:0]                 row;
  logic [15:0]                rd_data;

  logic [7:0] glyph;
  logic [4:0] rows;
  logic       last;
  logic       drawable;
  logic       out_free;
  logic       out_load;
  logic       in_beat;

  assign in_beat   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;

  assign glyph = item.char_code - btr_pkg::FIRST_GLYPH;
  assign rows  = (glyph_height > 5'(btr_pkg::MAX_ROWS)) ? 5'(btr_pkg::MAX_ROWS)
                                                         : glyph_height;
  assign last  = (5'(row + 5'd1) == rows);

  // base + rows against the table depth comes from the adder in the check step
  assign drawable = (item.char_code >= btr_pkg::FIRST_GLYPH) &&
                    (glyph < 8'(btr_pkg::GLYPH_COUNT)) &&
                    !alu_rsp.gt && (rows != 5'd0);

  btr_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  btr_font_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      btr_pkg::ST_IDLE: begin
        if (in_beat) begin
          state_next = btr_pkg::ST_DECODE;
        end
      end
      btr_pkg::ST_DECODE: begin
        state_next = btr_pkg::ST_IDLE;
        if (item.kind == btr_pkg::KIND_CHAR) begin
          if (item.char_code == btr_pkg::NEWLINE_CODE) begin
            state_next = btr_pkg::ST_NEWLINE;
          end else begin
            state_next = btr_pkg::ST_MUL;
          end
        end
      end
      btr_pkg::ST_NEWLINE: state_next = btr_pkg::ST_IDLE;
      btr_pkg::ST_MUL: begin
        if (mul_step == 3'd4) begin
          state_next = btr_pkg::ST_CHECK;
        end
      end
      btr_pkg::ST_CHECK: begin
        state_next = drawable ? btr_pkg::ST_FETCH : btr_pkg::ST_ADVANCE;
      end
      btr_pkg::ST_FETCH: state_next = btr_pkg::ST_ROW;
      btr_pkg::ST_ROW: begin
        if (out_free && last) begin
          state_next = btr_pkg::ST_ADVANCE;
        end
      end
      btr_pkg::ST_ADVANCE: state_next = btr_pkg::ST_WRAP;
      btr_pkg::ST_WRAP: begin
        state_next = alu_rsp.gt ? btr_pkg::ST_NEWLINE : btr_pkg::ST_IDLE;
      end
      default: state_next = btr_pkg::ST_IDLE;
    endcase
  end

  // outputs: adder operands, memory port, handshakes
  always_comb begin
    alu_req  = '0;
    mem_req  = '0;
    out_load = 1'b0;
    in_ready = 1'b0;
    mem_req.wr_addr = item.table_index;
    mem_req.wr_data = item.table_word;
    mem_req.rd_addr = addr;
    case (state)
      btr_pkg::ST_IDLE: in_ready = 1'b1;
      btr_pkg::ST_DECODE: begin
        mem_req.wr_en = (item.kind == btr_pkg::KIND_TABLE) &&
                        (item.table_index < btr_pkg::ADDR_W'(btr_pkg::TABLE_DEPTH));
      end
      btr_pkg::ST_NEWLINE: begin
        alu_req.a = btr_pkg::SUM_W'(cursor_y);
        alu_req.b = btr_pkg::SUM_W'(glyph_height);
      end
      btr_pkg::ST_MUL: begin
        // one shift-add step per bit of the glyph height
        alu_req.a = btr_pkg::SUM_W'(acc);
        if (glyph_height[mul_step]) begin
          alu_req.b = btr_pkg::SUM_W'(glyph) << mul_step;
        end
      end
      btr_pkg::ST_CHECK: begin
        alu_req.a   = btr_pkg::SUM_W'(acc);
        alu_req.b   = btr_pkg::SUM_W'(rows);
        alu_req.lim = btr_pkg::SUM_W'(btr_pkg::TABLE_DEPTH);
      end
      btr_pkg::ST_FETCH: mem_req.rd_en = 1'b1;
      btr_pkg::ST_ROW: begin
        alu_req.a     = btr_pkg::SUM_W'(cursor_y);
        alu_req.b     = btr_pkg::SUM_W'(row);
        out_load      = out_free;
        mem_req.rd_en = out_free && !last;
      end
      btr_pkg::ST_ADVANCE: begin
        alu_req.a = btr_pkg::SUM_W'(cursor_x);
        alu_req.b = btr_pkg::SUM_W'(glyph_width);
      end
      btr_pkg::ST_WRAP: begin
        alu_req.a   = btr_pkg::SUM_W'(cursor_x);
        alu_req.b   = btr_pkg::SUM_W'(glyph_width);
        alu_req.lim = btr_pkg::SUM_W'(clip_right);
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= btr_pkg::ST_IDLE;
      out_valid    <= 1'b0;
      cursor_x     <= '0;
      cursor_y     <= '0;
      glyph_width  <= 5'd7;
      glyph_height <= 5'd10;
      clip_left    <= '0;
      clip_right   <= 16'd320;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          btr_pkg::REG_GLYPH_WIDTH:  glyph_width  <= cfg_data[4:0];
          btr_pkg::REG_GLYPH_HEIGHT: glyph_height <= cfg_data[4:0];
          btr_pkg::REG_CLIP_LEFT:    clip_left    <= cfg_data;
          btr_pkg::REG_CLIP_RIGHT:   clip_right   <= cfg_data;
          default: begin
            clip_right <= clip_right;
          end
        endcase
      end
      case (state)
        btr_pkg::ST_DECODE: begin
          if (item.kind == btr_pkg::KIND_CURSOR) begin
            cursor_x <= item.pos_x;
            cursor_y <= item.pos_y;
          end
        end
        btr_pkg::ST_NEWLINE: begin
          cursor_y <= alu_rsp.sum[15:0];
          cursor_x <= clip_left;
        end
        btr_pkg::ST_ADVANCE: cursor_x <= alu_rsp.sum[15:0];
        default: begin
          cursor_x <= cursor_x;
        end
      endcase
    end
  end

  // sequencer datapath, no reset needed
  always_ff @(posedge clk) begin
    if (in_beat) begin
      item <= in_data;
    end
    case (state)
      btr_pkg::ST_DECODE: begin
        acc      <= '0;
        mul_step <= '0;
      end
      btr_pkg::ST_MUL: begin
        acc      <= alu_rsp.sum[btr_pkg::ACC_W-1:0];
        mul_step <= mul_step + 3'd1;
      end
      btr_pkg::ST_CHECK: begin
        addr <= acc[btr_pkg::ADDR_W-1:0];
        row  <= '0;
      end
      btr_pkg::ST_FETCH: addr <= addr + btr_pkg::ADDR_W'(1);
      btr_pkg::ST_ROW: begin
        if (out_load) begin
          row  <= row + 5'd1;
          addr <= addr + btr_pkg::ADDR_W'(1);
        end
      end
      default: begin
        row <= row;
      end
    endcase
    if (out_load) begin
      out_data.row_x      <= cursor_x;
      out_data.row_y      <= alu_rsp.sum[15:0];
      out_data.pixel_mask <= rd_data & btr_pkg::width_mask(glyph_width);
      out_data.last_row   <= last;
    end
  end

endmodule

@@ rtl/btr_alu.sv @@
// ----------------------------------------------------------------------------
// btr_alu
// Shared adder with limit compare, used by all but idle, decode, fetch step.
// ----------------------------------------------------------------------------
module btr_alu (
  input  btr_pkg::alu_req_t req,
  output btr_pkg::alu_rsp_t rsp
);

  always_comb begin
    rsp.sum = req.a + req.b;
    rsp.gt  = (rsp.sum > req.lim);
  end

endmodule

@@ rtl/btr_font_mem.sv @@
// ----------------------------------------------------------------------------
// btr_font_mem
// Font table memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module btr_font_mem (
  input  logic              clk,
  input  btr_pkg::mem_req_t req,
  output logic [15:0]       rd_data
);

  logic [15:0] mem [btr_pkg::TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

@@ rtl/btr_checker.sv @@
// ----------------------------------------------------------------------------
// btr_checker
// Port-level checks of the bitmap text row renderer, bound to the top level.
// ----------------------------------------------------------------------------
module btr_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input btr_pkg::out_t     out_data
);

  logic        open_char;
  logic [15:0] prev_x;
  logic [15:0] prev_y;
  logic        out_beat;

  assign out_beat = out_valid && out_ready;

  // tracks the rows of a character still being sent
  always_ff @(posedge clk) begin
    if (rst) begin
      open_char <= 1'b0;
    end else if (out_beat) begin
      open_char <= !out_data.last_row;
    end
  end

  always_ff @(posedge clk) begin
    if (out_beat) begin
      prev_x <= out_data.row_x;
      prev_y <= out_data.row_y;
    end
  end

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output beat shown straight after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled output beat dropped or changed");

  a_row_step: assert property (@(posedge clk) disable iff (rst)
    out_beat && open_char |->
      out_data.row_x == prev_x && out_data.row_y == 16'(prev_y + 16'd1))
    else $error("rows of one character not on one column, one line apart");

  a_no_input_mid_char: assert property (@(posedge clk) disable iff (rst)
    out_beat && !out_data.last_row |=> !in_ready)
    else $error("input taken while a character still has rows to send");

endmodule

bind bitmap_text_row_renderer btr_checker u_btr_checker (.*);

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bitmap text row renderer. The low end of the
// font table is preloaded, then a directed sequence and random traffic run
// over several glyph size and clip settings; characters are only drawn from
// font words already written. A local row predictor tracks the pen and the
// font words, and each output beat is checked against its predicted row.
// ----------------------------------------------------------------------------
module tb;

  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PRELOAD_WORDS  = 100;
  localparam int RANDOM_ITEMS   = 18;
  localparam btr_pkg::kind_t KIND_UNUSED = btr_pkg::kind_t'(2'd3);

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  btr_pkg::in_t      in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  btr_pkg::out_t     out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  btr_pkg::cfg_reg_t cfg_index = btr_pkg::REG_GLYPH_WIDTH;
  logic [15:0]       cfg_data  = '0;

  // predictor state
  logic [4:0]  glyph_w    = 5'd7;
  logic [4:0]  glyph_h    = 5'd10;
  logic [15:0] left_edge  = 16'd0;
  logic [15:0] right_edge = 16'd320;
  logic [15:0] pen_x      = 16'd0;
  logic [15:0] pen_y      = 16'd0;
  logic [15:0] font_words [btr_pkg::TABLE_DEPTH];
  // font words already queued for writing
  bit          word_set   [btr_pkg::TABLE_DEPTH];

  btr_pkg::in_t  pending_items [$];
  btr_pkg::out_t expected_rows [$];
  int   items_queued = 0;
  int   items_taken  = 0;
  int   error_count  = 0;

  int   burst_left = 0;
  int   gap_left   = 0;
  int   stall_mode = 0;
  int   mode_left  = 0;
  logic [7:0] ready_pattern = 8'h01;
  int   quiet_cycles = 0;

  bitmap_text_row_renderer uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  task automatic line_feed();
    pen_y = pen_y + 16'(glyph_h);
    pen_x = left_edge;
  endtask

  // works out the rows a beat produces, stores font words and moves the pen
  task automatic predict_item(input btr_pkg::in_t item);
    int unsigned   rows;
    int unsigned   glyph;
    int unsigned   base;
    logic [15:0]   keep;
    btr_pkg::out_t row;
    case (item.kind)
      btr_pkg::KIND_CURSOR: begin
        pen_x = item.pos_x;
        pen_y = item.pos_y;
      end
      btr_pkg::KIND_TABLE: begin
        if (item.table_index < btr_pkg::TABLE_DEPTH)
          font_words[item.table_index] = item.table_word;
      end
      btr_pkg::KIND_CHAR: begin
        if (item.char_code == btr_pkg::NEWLINE_CODE) begin
          line_feed();
        end else begin
          rows = (glyph_h < btr_pkg::MAX_ROWS) ? glyph_h : btr_pkg::MAX_ROWS;
          for (int b = 0; b < 16; b++) keep[15-b] = (b < glyph_w);
          if (item.char_code >= btr_pkg::FIRST_GLYPH) begin
            glyph = int'(item.char_code) - int'(btr_pkg::FIRST_GLYPH);
            base  = glyph * glyph_h;
            if (glyph < btr_pkg::GLYPH_COUNT && base + rows <= btr_pkg::TABLE_DEPTH) begin
              for (int r = 0; r < rows; r++) begin
                row.row_x      = pen_x;
                row.row_y      = pen_y + 16'(r);
                row.pixel_mask = font_words[base + r] & keep;
                row.last_row   = (r + 1 == rows);
                expected_rows.push_back(row);
              end
            end
          end
          // codes outside the table still move the pen
          pen_x = pen_x + 16'(glyph_w);
          if (17'(pen_x) + 17'(glyph_w) > 17'(right_edge)) line_feed();
        end
      end
      default: ;
    endcase
  endtask

  // sender: bursts of beats with random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_item(in_data);
        items_taken++;
      end
      if (in_valid && !in_ready) begin
        // hold the beat
      end else if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_items.size() != 0) begin
        in_valid <= 1'b1;
        in_data  <= pending_items.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern changes when its random mode count runs out
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      mode_left <= 0;
    end else if (mode_left == 0) begin
      stall_mode    <= $urandom_range(0, 3);
      mode_left     <= $urandom_range(8, 80);
      ready_pattern <= 8'($urandom) | 8'h01;
      out_ready     <= 1'b1;
    end else begin
      mode_left <= mode_left - 1;
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: begin
          out_ready     <= ready_pattern[0];
          ready_pattern <= {ready_pattern[0], ready_pattern[7:1]};
        end
      endcase
    end
  end

  // output check and watchdog
  always @(posedge clk) begin : monitor
    btr_pkg::out_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_rows.size() == 0) begin
          report_mismatch($sformatf("unexpected row x=%0h y=%0h mask=%0h",
                                    out_data.row_x, out_data.row_y, out_data.pixel_mask));
        end else begin
          want = expected_rows.pop_front();
          if (out_data.row_x !== want.row_x)
            report_mismatch($sformatf("row_x got %0h want %0h", out_data.row_x, want.row_x));
          if (out_data.row_y !== want.row_y)
            report_mismatch($sformatf("row_y got %0h want %0h", out_data.row_y, want.row_y));
          if (out_data.pixel_mask !== want.pixel_mask)
            report_mismatch($sformatf("pixel_mask got %0h want %0h",
                                      out_data.pixel_mask, want.pixel_mask));
          if (out_data.last_row !== want.last_row)
            report_mismatch($sformatf("last_row got %0b want %0b",
                                      out_data.last_row, want.last_row));
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic btr_pkg::in_t rand_item(input btr_pkg::kind_t k);
    btr_pkg::in_t it;
    it.kind        = k;
    it.char_code   = 8'($urandom);
    it.pos_x       = 16'($urandom);
    it.pos_y       = 16'($urandom);
    it.table_index = 11'($urandom);
    it.table_word  = 16'($urandom);
    return it;
  endfunction

  // true when drawing the code reads only font words already queued
  function automatic bit rows_written(input logic [7:0] code);
    int unsigned rows;
    int unsigned glyph;
    int unsigned base;
    bit          ok;
    ok   = 1'b1;
    rows = (glyph_h < btr_pkg::MAX_ROWS) ? glyph_h : btr_pkg::MAX_ROWS;
    if (code >= btr_pkg::FIRST_GLYPH) begin
      glyph = int'(code) - int'(btr_pkg::FIRST_GLYPH);
      base  = glyph * glyph_h;
      if (glyph < btr_pkg::GLYPH_COUNT && base + rows <= btr_pkg::TABLE_DEPTH) begin
        for (int r = 0; r < rows; r++) if (!word_set[base + r]) ok = 1'b0;
      end
    end
    return ok;
  endfunction

  // keeps the code when its rows are written, else picks one that is
  function automatic logic [7:0] pick_code(input logic [7:0] code);
    logic [7:0] usable [$];
    logic [7:0] c;
    if (rows_written(code)) return code;
    for (int g = 0; g < int'(btr_pkg::GLYPH_COUNT); g++) begin
      c = 8'(g) + btr_pkg::FIRST_GLYPH;
      if (rows_written(c)) usable.push_back(c);
    end
    if (usable.size() == 0) return 8'd0;
    return usable[$urandom_range(0, usable.size() - 1)];
  endfunction

  task automatic send_char(input logic [7:0] code);
    btr_pkg::in_t it;
    it = rand_item(btr_pkg::KIND_CHAR);
    it.char_code = pick_code(code);
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic send_cursor(input logic [15:0] x, input logic [15:0] y);
    btr_pkg::in_t it;
    it = rand_item(btr_pkg::KIND_CURSOR);
    it.pos_x = x;
    it.pos_y = y;
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic send_word(input logic [10:0] idx, input logic [15:0] word);
    btr_pkg::in_t it;
    it = rand_item(btr_pkg::KIND_TABLE);
    it.table_index = idx;
    it.table_word  = word;
    if (idx < btr_pkg::TABLE_DEPTH) word_set[idx] = 1'b1;
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic send_unused();
    pending_items.push_back(rand_item(KIND_UNUSED));
    items_queued++;
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (items_taken != items_queued || expected_rows.size() != 0);
    // a character with no rows may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input btr_pkg::cfg_reg_t idx, input logic [15:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    case (idx)
      btr_pkg::REG_GLYPH_WIDTH:  glyph_w    = value[4:0];
      btr_pkg::REG_GLYPH_HEIGHT: glyph_h    = value[4:0];
      btr_pkg::REG_CLIP_LEFT:    left_edge  = value;
      default:                   right_edge = value;
    endcase
  endtask

  task automatic configure(input logic [15:0] w, input logic [15:0] h,
                           input logic [15:0] l, input logic [15:0] r);
    write_reg(btr_pkg::REG_GLYPH_WIDTH, w);
    write_reg(btr_pkg::REG_GLYPH_HEIGHT, h);
    write_reg(btr_pkg::REG_CLIP_LEFT, l);
    write_reg(btr_pkg::REG_CLIP_RIGHT, r);
  endtask

  task automatic send_random(input int count);
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 19);
      if (pick <= 8 || pick == 19) begin
        send_char(8'($urandom_range(32, 127)));
      end else if (pick == 9) begin
        send_char(btr_pkg::NEWLINE_CODE);
      end else if (pick <= 11) begin
        send_char(8'($urandom));
      end else if (pick <= 13) begin
        if ($urandom_range(0, 1) == 0)
          send_cursor(16'($urandom), 16'($urandom));
        else
          send_cursor(right_edge - 16'($urandom_range(0, 20)), 16'($urandom));
      end else if (pick <= 17) begin
        if ($urandom_range(0, 7) == 0)
          send_word(11'($urandom_range(btr_pkg::TABLE_DEPTH, 2047)), 16'($urandom));
        else
          send_word(11'($urandom_range(0, btr_pkg::TABLE_DEPTH - 1)), 16'($urandom));
      end else begin
        send_unused();
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // fill the low end of the font table
    for (int i = 0; i < PRELOAD_WORDS; i++) send_word(11'(i), 16'($urandom));

    // directed beats at the reset setting
    send_char(btr_pkg::FIRST_GLYPH);
    send_char(8'd128);
    send_char(8'd255);
    send_char(8'd0);
    send_char(8'd31);
    send_char(btr_pkg::NEWLINE_CODE);
    send_word(11'd50, 16'hFFFF);
    send_word(11'd51, 16'h0001);
    send_char(8'd37);
    send_word(11'd2047, 16'h0000);
    send_word(11'd1536, 16'h0000);
    send_char(8'd37);
    send_cursor(16'hFFFF, 16'hFFFF);
    send_char(8'd33);
    send_cursor(16'd306, 16'd5);
    send_char(8'd40);
    send_char(8'd41);
    send_unused();
    send_cursor(16'd315, 16'd0);
    send_char(8'd36);
    send_char(btr_pkg::NEWLINE_CODE);
    wait_idle();

    // widest and tallest glyph, full clip range
    configure(16'd16, 16'd16, 16'd0, 16'hFFFF);
    send_random(RANDOM_ITEMS);
    wait_idle();

    // zero width, single row, last glyph of the table
    configure(16'd0, 16'd1, 16'd100, 16'd200);
    send_char(8'd127);
    send_random(RANDOM_ITEMS);
    wait_idle();

    // upper data bits dropped: width 31, zero height, every glyph wraps
    configure(16'hFFFF, 16'hFFE0, 16'hFFFF, 16'd0);
    send_random(RANDOM_ITEMS);
    wait_idle();

    // width above 16 and a height that runs many glyphs past the table
    configure(16'd17, 16'h001F, 16'd0, 16'hFFFF);
    send_random(RANDOM_ITEMS);
    wait_idle();

    for (int p = 0; p < 3; p++) begin
      logic [15:0] l;
      l = 16'($urandom_range(0, 300));
      configure({11'($urandom), 5'($urandom_range(1, 16))},
                {11'($urandom), 5'($urandom_range(1, 16))},
                l, l + 16'($urandom_range(20, 400)));
      send_random(RANDOM_ITEMS);
      wait_idle();
    end

    if (expected_rows.size() != 0)
      report_mismatch($sformatf("%0d rows never arrived", expected_rows.size()));

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
